// ===== rtl/core/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder and its checker.
// ---------------------------------------------------------------------------
package u8u16_pkg;

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        result_kind;
        logic        end_of_string;
    } res_t;

    localparam logic RESULT_UNIT  = 1'b0;
    localparam logic RESULT_ERROR = 1'b1;

    localparam logic [7:0]  LEAD2_MIN = 8'hC2;
    localparam logic [7:0]  LEAD2_MAX = 8'hDF;
    localparam logic [7:0]  LEAD3_MIN = 8'hE0;
    localparam logic [7:0]  LEAD3_MAX = 8'hEF;
    localparam logic [7:0]  LEAD4_MIN = 8'hF0;
    localparam logic [7:0]  LEAD4_MAX = 8'hF4;

    localparam logic [20:0] MIN_CP_2  = 21'h000080;
    localparam logic [20:0] MIN_CP_3  = 21'h000800;
    localparam logic [20:0] MIN_CP_4  = 21'h010000;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [15:0] HIGH_BASE = 16'hD800;
    localparam logic [15:0] LOW_BASE  = 16'hDC00;

    // Leading six bits of a high and a low surrogate unit.
    localparam logic [5:0]  HIGH_TAG  = 6'b110110;
    localparam logic [5:0]  LOW_TAG   = 6'b110111;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/core/utf8_to_utf16_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Strict UTF-8 to UTF-16 transcoder, one byte in, up to two units out.
// ---------------------------------------------------------------------------
// The block takes one UTF-8 byte per clock while s_axis_tready is high and
// decodes it in the cycle it is accepted; its results are written into a
// four-entry result queue and read out from its head. A byte that completes
// a code point above FFFF yields a surrogate pair, which leaves as two
// successive output items; the output side drains one unit per clock while
// m_axis_tready is high. Input ready is held high while at least two
// queue entries are free. On the first error in a string one error item is
// sent and the rest of the string is dropped; the last byte of the string
// then brings a closing error item unless the error fell on that byte.
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // end_of_string
);

    logic [1:0]  expect_reg, expect_next;
    logic [20:0] partial_reg, partial_next;
    logic [1:0]  seqlen_reg, seqlen_next;
    logic        err_reg, err_next;

    res_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic        in_fire, out_fire;
    logic [7:0]  b;
    logic        last;
    logic [1:0]  n_res;
    res_t        res0, res1;
    logic [20:0] cont_cp;
    logic [1:0]  expect_dec;
    logic [20:0] minimum;
    logic [19:0] cp_off;

    assign b        = s_axis_tdata;
    assign last     = s_axis_tlast;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    assign cont_cp    = {partial_reg[14:0], b[5:0]};
    assign expect_dec = expect_reg - 2'd1;
    assign cp_off     = cont_cp[19:0] - MIN_CP_4[19:0];

    always_comb
    begin
        unique case (seqlen_reg)
            2'd1:    minimum = MIN_CP_2;
            2'd2:    minimum = MIN_CP_3;
            default: minimum = MIN_CP_4;
        endcase
    end

    // Decode of the byte at the input against the sequence state.
    always_comb
    begin
        logic raise;
        raise        = 1'b0;
        n_res        = 2'd0;
        res0         = '{code_unit: 16'h0000, result_kind: RESULT_UNIT, end_of_string: last};
        res1         = '{code_unit: 16'h0000, result_kind: RESULT_UNIT, end_of_string: last};
        expect_next  = expect_reg;
        partial_next = partial_reg;
        seqlen_next  = seqlen_reg;
        err_next     = err_reg;

        if (err_reg)
        begin
            // Bytes after an error are dropped until the end of the string.
            if (last)
            begin
                raise = 1'b1;
            end
        end
        else if (expect_reg == 2'd0)
        begin
            if (!b[7])
            begin
                n_res          = 2'd1;
                res0.code_unit = {8'h00, b};
            end
            else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
            begin
                partial_next = {16'h0000, b[4:0]};
                expect_next  = 2'd1;
                seqlen_next  = 2'd1;
                raise        = last;
            end
            else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
            begin
                partial_next = {17'h00000, b[3:0]};
                expect_next  = 2'd2;
                seqlen_next  = 2'd2;
                raise        = last;
            end
            else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
            begin
                partial_next = {18'h00000, b[2:0]};
                expect_next  = 2'd3;
                seqlen_next  = 2'd3;
                raise        = last;
            end
            else
            begin
                raise = 1'b1;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            raise = 1'b1;
        end
        else if (expect_dec != 2'd0)
        begin
            partial_next = cont_cp;
            expect_next  = expect_dec;
            raise        = last;
        end
        else
        begin
            expect_next  = 2'd0;
            partial_next = '0;
            seqlen_next  = 2'd0;
            if (cont_cp < minimum || cont_cp > MAX_CP ||
                (cont_cp >= SURR_LO && cont_cp <= SURR_HI))
            begin
                raise = 1'b1;
            end
            else if (cont_cp <= BMP_MAX)
            begin
                n_res          = 2'd1;
                res0.code_unit = cont_cp[15:0];
            end
            else
            begin
                n_res              = 2'd2;
                res0.code_unit     = HIGH_BASE + {6'h00, cp_off[19:10]};
                res0.end_of_string = 1'b0;
                res1.code_unit     = LOW_BASE + {6'h00, cp_off[9:0]};
            end
        end

        if (raise)
        begin
            n_res            = 2'd1;
            res0.code_unit   = 16'h0000;
            res0.result_kind = RESULT_ERROR;
            expect_next      = 2'd0;
            partial_next     = '0;
            seqlen_next      = 2'd0;
            err_next         = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg  <= 2'd0;
            partial_reg <= '0;
            seqlen_reg  <= 2'd0;
            err_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            expect_reg  <= expect_next;
            partial_reg <= partial_next;
            seqlen_reg  <= seqlen_next;
            err_reg     <= err_next;
        end
    end

    // Result queue: up to two writes and one read per cycle.
    always_ff @(posedge clk)
    begin
        if (in_fire && n_res != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (in_fire && n_res == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (in_fire ? CNT_W'(n_res) : CNT_W'(0))
                                   - (out_fire ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign s_axis_tready = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = queue_reg[rd_ptr_reg].code_unit;
    assign m_axis_tuser  = queue_reg[rd_ptr_reg].result_kind;
    assign m_axis_tlast  = queue_reg[rd_ptr_reg].end_of_string;

endmodule

// ===== rtl/core/u8u16_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u8u16_checker
// Port-level checks of the UTF-8 to UTF-16 decoder, bound to the top level.
// ---------------------------------------------------------------------------
module u8u16_checker
    import u8u16_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // An error item carries no code unit.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == RESULT_ERROR |-> m_axis_tdata == 16'h0000)
        else $error("error item with nonzero code unit");

    // A high surrogate is never the end of a string.
    a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == RESULT_UNIT && m_axis_tdata[15:10] == HIGH_TAG
        |-> !m_axis_tlast)
        else $error("high surrogate marked as end of string");

    // Both halves of a pair are queued together, so the low half follows at once.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == RESULT_UNIT &&
        m_axis_tdata[15:10] == HIGH_TAG
        |=> m_axis_tvalid && m_axis_tuser == RESULT_UNIT && m_axis_tdata[15:10] == LOW_TAG)
        else $error("high surrogate not followed by low surrogate");

    // Input is held off only while results are waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty result queue");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output item changed");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_u8u16_checker (.*);
